[rtl/qs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qs_pkg;

    localparam int N_ENTRIES  = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W  = $clog2(N_ENTRIES);
    localparam int CNT_W   = $clog2(N_ENTRIES + 1);
    localparam int SPAN_W  = 2 * ADDR_W;
    localparam int IO_W    = 32;
    localparam int RIDX_W  = 10;
    localparam int TOTAL_W = 11;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [SPAN_W-1:0]     span_t;

    // one access of the element memory: one write and one read per cycle
    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } mem_req_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_UNSORTED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POPW,
        S_PIV,
        S_CMP,
        S_SW1,
        S_SW2,
        S_FIN,
        S_FSW1,
        S_FSW2,
        S_PUSH1,
        S_PUSH2,
        S_POP
    } sort_state_t;

endpackage
`default_nettype wire

[rtl/qs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/qs_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none
module qs_sorter
    import qs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     go,
    input  wire cnt_t     count,
    output logic          busy,
    output mem_req_t      elem_req,
    input  wire word_t    elem_rdata
);

    sort_state_t state_reg, state_next;
    addr_t lo_reg, lo_next;
    addr_t hi_reg, hi_next;
    addr_t j_reg, j_next;
    addr_t nx_reg, nx_next;
    word_t pivot_reg, pivot_next;
    word_t dj_reg, dj_next;
    cnt_t  sp_reg, sp_next;

    logic  stk_we;
    addr_t stk_waddr;
    span_t stk_wdata;
    addr_t stk_raddr;
    span_t stk_rdata;

    addr_t j_inc;
    logic  last_j;
    logic  less;

    qs_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (N_ENTRIES)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign j_inc  = addr_t'(j_reg + 1'b1);
    assign last_j = (j_inc == hi_reg);
    assign less   = $signed(elem_rdata) < $signed(pivot_reg);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        nx_reg    <= nx_next;
        pivot_reg <= pivot_next;
        dj_reg    <= dj_next;
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        nx_next    = nx_reg;
        pivot_next = pivot_reg;
        dj_next    = dj_reg;
        sp_next    = sp_reg;
        elem_req   = '0;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[ADDR_W-1:0];
        stk_wdata  = '0;
        stk_raddr  = addr_t'(sp_reg - 1'b1);

        case (state_reg)
            S_IDLE:
            begin
                if (go && (count >= cnt_t'(2)))
                begin
                    lo_next        = '0;
                    hi_next        = addr_t'(count - 1'b1);
                    elem_req.raddr = addr_t'(count - 1'b1);
                    sp_next        = '0;
                    state_next     = S_PIV;
                end
            end
            S_POPW:
            begin
                lo_next        = stk_rdata[SPAN_W-1:ADDR_W];
                hi_next        = stk_rdata[ADDR_W-1:0];
                elem_req.raddr = stk_rdata[ADDR_W-1:0];
                state_next     = S_PIV;
            end
            S_PIV:
            begin
                pivot_next     = elem_rdata;
                nx_next        = lo_reg;
                j_next         = lo_reg;
                elem_req.raddr = lo_reg;
                state_next     = S_CMP;
            end
            S_CMP:
            begin
                if (less && (nx_reg != j_reg))
                begin
                    // fetch the element at the split point for a swap
                    dj_next        = elem_rdata;
                    elem_req.raddr = nx_reg;
                    state_next     = S_SW1;
                end
                else
                begin
                    if (less)
                    begin
                        nx_next = addr_t'(nx_reg + 1'b1);
                    end
                    j_next = j_inc;
                    if (last_j)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        elem_req.raddr = j_inc;
                    end
                end
            end
            S_SW1:
            begin
                elem_req.we    = 1'b1;
                elem_req.waddr = j_reg;
                elem_req.wdata = elem_rdata;
                state_next     = S_SW2;
            end
            S_SW2:
            begin
                elem_req.we    = 1'b1;
                elem_req.waddr = nx_reg;
                elem_req.wdata = dj_reg;
                nx_next        = addr_t'(nx_reg + 1'b1);
                j_next         = j_inc;
                if (last_j)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    elem_req.raddr = j_inc;
                    state_next     = S_CMP;
                end
            end
            S_FIN:
            begin
                if (nx_reg == hi_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    elem_req.raddr = nx_reg;
                    state_next     = S_FSW1;
                end
            end
            S_FSW1:
            begin
                elem_req.we    = 1'b1;
                elem_req.waddr = hi_reg;
                elem_req.wdata = elem_rdata;
                state_next     = S_FSW2;
            end
            S_FSW2:
            begin
                elem_req.we    = 1'b1;
                elem_req.waddr = nx_reg;
                elem_req.wdata = pivot_reg;
                state_next     = S_PUSH1;
            end
            S_PUSH1:
            begin
                if (({1'b0, nx_reg} > ({1'b0, lo_reg} + 1'b1)) &&
                    (sp_reg < cnt_t'(N_ENTRIES)))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, addr_t'(nx_reg - 1'b1)};
                    sp_next   = cnt_t'(sp_reg + 1'b1);
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if (({1'b0, hi_reg} > ({1'b0, nx_reg} + 1'b1)) &&
                    (sp_reg < cnt_t'(N_ENTRIES)))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {addr_t'(nx_reg + 1'b1), hi_reg};
                    sp_next   = cnt_t'(sp_reg + 1'b1);
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sp_next    = cnt_t'(sp_reg - 1'b1);
                    state_next = S_POPW;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_scan_below_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg < hi_reg))
        else $error("scan index reached pivot position");

    a_split_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP || state_reg == S_SW1 || state_reg == S_SW2)
        |-> (nx_reg <= j_reg))
        else $error("split point ahead of scan index");

    a_range_nontrivial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIV) |-> (lo_reg < hi_reg))
        else $error("partition started on a range of fewer than two elements");

endmodule
`default_nettype wire

[rtl/lomuto_quicksort_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Batch sorter. Loads (mode 0) append one word to the current batch; a load
// with is_last set closes the batch and starts an in-place ascending quicksort
// (Lomuto partition, last element of a range as pivot). Reads (mode 1) return
// the sorted word at read_index. A transaction is taken at a rising edge with
// start high and busy low; its single result appears on data_out,
// element_total and status for exactly one cycle, in the cycle after
// acceptance, marked by result_strobe. The receiver cannot stall: capture the
// result in that cycle. Loads and reads accept one transaction per cycle
// while busy is low. After the closing load, busy stays high for the whole
// sort, which owns both ports of the element memory: each partition of a
// range fetches the pivot, scans the range, swaps each word found below the
// pivot towards the front, ends the scan, swaps the pivot into place when it
// has to move, and then pushes each subrange of two or more words and pops
// the next range off the range stack. The sort is slowest when the words
// arrive already in order or are all equal. There is no clearing pass after
// reset.
module lomuto_quicksort_top
    import qs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      mode,
    input  wire logic signed [IO_W-1:0]    data_in,
    input  wire logic                      is_last,
    input  wire logic        [RIDX_W-1:0]  read_index,
    output logic                           result_strobe,
    output logic signed      [IO_W-1:0]    data_out,
    output logic             [TOTAL_W-1:0] element_total,
    output logic             [1:0]         status
);

    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    cnt_t    count_reg, count_next;
    logic    sorted_reg, sorted_next;
    logic    go_reg, go_next;
    logic    strobe_reg, strobe_next;
    logic    rd_ok_reg, rd_ok_next;
    status_t status_reg, status_next;

    logic     accept;
    logic     sort_busy;
    cnt_t     eff_count;
    logic     full;
    mem_req_t host_req;
    mem_req_t sort_req;
    mem_req_t elem_req;
    word_t    elem_rdata;

    qs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (N_ENTRIES)
    ) u_elem (
        .clk   (clk),
        .we    (elem_req.we),
        .waddr (elem_req.waddr),
        .wdata (elem_req.wdata),
        .raddr (elem_req.raddr),
        .rdata (elem_rdata)
    );

    qs_sorter u_sorter (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go_reg),
        .count      (count_reg),
        .busy       (sort_busy),
        .elem_req   (sort_req),
        .elem_rdata (elem_rdata)
    );

    // hold off new transactions from the closing load until the sort ends
    assign busy   = go_reg | sort_busy;
    assign accept = start & ~busy;

    // a load into a sorted batch opens a new one
    assign eff_count = sorted_reg ? '0 : count_reg;
    assign full      = (eff_count == cnt_t'(N_ENTRIES));

    always_comb
    begin
        host_req       = '0;
        host_req.we    = accept && (mode == MODE_LOAD) && !full;
        host_req.waddr = eff_count[ADDR_W-1:0];
        host_req.wdata = DATA_WIDTH'(data_in);
        host_req.raddr = addr_t'(read_index);
    end

    // the sort owns the memory whenever busy is high
    assign elem_req = busy ? sort_req : host_req;

    always_comb
    begin
        count_next  = count_reg;
        sorted_next = sorted_reg;
        go_next     = 1'b0;
        strobe_next = accept;
        rd_ok_next  = 1'b0;
        status_next = ST_OK;

        if (accept)
        begin
            if (mode == MODE_LOAD)
            begin
                count_next  = full ? eff_count : cnt_t'(eff_count + 1'b1);
                sorted_next = is_last;
                go_next     = is_last;
                status_next = full ? ST_FULL : ST_OK;
            end
            else
            begin
                if (!sorted_reg)
                begin
                    status_next = ST_UNSORTED;
                end
                else if (CMP_W'(read_index) >= CMP_W'(count_reg))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sorted_reg <= 1'b0;
            go_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            go_reg     <= go_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg  <= rd_ok_next;
        status_reg <= status_next;
    end

    // read data comes straight from the memory output register
    assign result_strobe = strobe_reg;
    assign data_out      = rd_ok_reg ? IO_W'($signed(elem_rdata)) : '0;
    assign element_total = TOTAL_W'(count_reg);
    assign status        = status_reg;

    a_kick_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> !sort_busy)
        else $error("sort started while a sort was running");

    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_LOAD) && is_last) |=> (busy && result_strobe))
        else $error("closing load did not raise busy with its result");

endmodule
`default_nettype wire
